// ===== rtl/core/sis_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sis_pkg - shared constants for the sorted integer set
// Field widths, command codes, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package sis_pkg;

  // parameter defaults
  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int ELEM_W   = 32;
  localparam int SIZE_W   = 5;

  // commands
  localparam logic [CMD_W-1:0] CMD_INSERT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INTERSECT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP      = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOCHANGE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUMP_ELEM = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

endpackage
`default_nettype wire

// ===== rtl/core/sis_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sis_ram - entry store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sis_ram #(
  parameter int DEPTH = sis_pkg::CAPACITY_DEF,
  parameter int WIDTH = sis_pkg::VALUE_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic signed [WIDTH-1:0]  wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic signed [WIDTH-1:0]  rdata
);

  logic signed [WIDTH-1:0] mem [DEPTH];

  // write one word and read one word each cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/sorted_integer_set_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_integer_set_top - ordered set of distinct signed integers
// Keeps up to CAPACITY values in ascending order in a single-port-read store.
// Supports insert, delete, intersect (stream with commit) and dump.
// ----------------------------------------------------------------------------
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+-------------------
//  input   | in_cmd in_value in_element_valid              | start & !busy
//          | in_final_element                              |
//  result  | out_status out_element out_size_now           | out_valid, 1 cycle
//          | out_end_of_run                                |
//
//  One comparator and one index counter walk the store under a small
//  sequencer; every store read has an address step and a registered-data step.
//  Insert/delete: read and compare per entry scanned, read and write per
//  entry moved. Intersect: scan as above; commit reads each entry, writes
//  back marked ones. Dump: read, output per element; empty set answers at once.
//  Reset is synchronous; marks and fill count clear at once, no sweep.
//  busy stays high while an item is at work; results cannot be stalled.
// ----------------------------------------------------------------------------
module sorted_integer_set_top #(
  parameter int CAPACITY   = sis_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = sis_pkg::VALUE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic [sis_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic signed [VALUE_BITS-1:0]      in_value,
  input  wire logic                              in_element_valid,
  input  wire logic                              in_final_element,
  output      logic                              out_valid,
  output      logic [sis_pkg::STATUS_W-1:0]      out_status,
  output      logic signed [sis_pkg::ELEM_W-1:0] out_element,
  output      logic [sis_pkg::SIZE_W-1:0]        out_size_now,
  output      logic                              out_end_of_run
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SCAN_RD  = 9'b000000010,
    S_SCAN_CMP = 9'b000000100,
    S_SHIFT_RD = 9'b000001000,
    S_SHIFT_WR = 9'b000010000,
    S_PACK_RD  = 9'b000100000,
    S_PACK_WR  = 9'b001000000,
    S_DUMP_RD  = 9'b010000000,
    S_DUMP_OUT = 9'b100000000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [sis_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic signed [VALUE_BITS-1:0] key_r, key_nxt;
  logic                         scan_en_r, scan_en_nxt;
  logic                         final_r, final_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic [CW-1:0]                pos_r, pos_nxt;
  logic [CW-1:0]                wp_r, wp_nxt;
  logic [CW-1:0]                fill_r, fill_nxt;
  logic                         marks_r [CAPACITY];
  logic                         marks_nxt [CAPACITY];

  logic                         out_valid_r, out_valid_nxt;
  logic [sis_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [sis_pkg::ELEM_W-1:0]   out_element_r, out_element_nxt;
  logic [sis_pkg::SIZE_W-1:0]   out_size_r, out_size_nxt;
  logic                         out_last_r, out_last_nxt;

  // store port
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic signed [VALUE_BITS-1:0] ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic signed [VALUE_BITS-1:0] rd_data;

  // shared comparator and index arithmetic
  logic                         cmp_lt, cmp_eq;
  logic [CW-1:0]                idx_inc, idx_dec, fill_dec;
  logic signed [63:0]           rd_ext;
  logic [31:0]                  fill_ext;

  // scan outcome
  logic                         scan_done, scan_found;
  logic [CW-1:0]                scan_pos;

  // emit request
  logic                         emit;
  logic [sis_pkg::STATUS_W-1:0] emit_status;
  logic                         emit_elem, emit_last;

  logic                         accept;

  sis_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && (state_r == S_IDLE);
  assign cmp_lt  = (rd_data < key_r);
  assign cmp_eq  = (rd_data == key_r);
  assign idx_inc = idx_r + CW'(1);
  assign idx_dec = idx_r - CW'(1);
  assign fill_dec = fill_r - CW'(1);
  assign rd_ext  = 64'(rd_data);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    scan_en_nxt = scan_en_r;
    final_nxt   = final_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    wp_nxt      = wp_r;
    fill_nxt    = fill_r;
    for (int i = 0; i < CAPACITY; i++) begin
      marks_nxt[i] = marks_r[i];
    end
    ram_we      = 1'b0;
    ram_waddr   = idx_r[AW-1:0];
    ram_wdata   = rd_data;
    ram_raddr   = idx_r[AW-1:0];
    scan_done   = 1'b0;
    scan_found  = 1'b0;
    scan_pos    = idx_r;
    emit        = 1'b0;
    emit_status = sis_pkg::ST_DONE;
    emit_elem   = 1'b0;
    emit_last   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt     = in_cmd;
          key_nxt     = in_value;
          final_nxt   = in_final_element;
          scan_en_nxt = (in_cmd != sis_pkg::CMD_INTERSECT) || in_element_valid;
          idx_nxt     = '0;
          if (in_cmd == sis_pkg::CMD_DUMP) begin
            if (fill_r == '0) begin
              emit        = 1'b1;
              emit_status = sis_pkg::ST_EMPTY;
            end else begin
              state_nxt = S_DUMP_RD;
            end
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end

      // scan: issue a read, or stop at the end of the valid range or when the scan is off
      S_SCAN_RD: begin
        if (!scan_en_r || idx_r == fill_r) begin
          scan_done = 1'b1;
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        if (cmp_lt) begin
          idx_nxt   = idx_inc;
          state_nxt = S_SCAN_RD;
        end else begin
          scan_done  = 1'b1;
          scan_found = cmp_eq;
        end
      end

      // shift: up for insert, down for delete
      S_SHIFT_RD: begin
        if (cmd_r == sis_pkg::CMD_INSERT) begin
          if (idx_r == pos_r) begin
            ram_we    = 1'b1;
            ram_waddr = pos_r[AW-1:0];
            ram_wdata = key_r;
            marks_nxt[pos_r[AW-1:0]] = 1'b0;
            fill_nxt  = fill_r + CW'(1);
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            ram_raddr = idx_dec[AW-1:0];
            state_nxt = S_SHIFT_WR;
          end
        end else begin
          if (idx_inc == fill_r) begin
            marks_nxt[fill_dec[AW-1:0]] = 1'b0;
            fill_nxt  = fill_dec;
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            ram_raddr = idx_inc[AW-1:0];
            state_nxt = S_SHIFT_WR;
          end
        end
      end

      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        if (cmd_r == sis_pkg::CMD_INSERT) begin
          marks_nxt[idx_r[AW-1:0]] = marks_r[idx_dec[AW-1:0]];
          idx_nxt = idx_dec;
        end else begin
          marks_nxt[idx_r[AW-1:0]] = marks_r[idx_inc[AW-1:0]];
          idx_nxt = idx_inc;
        end
        state_nxt = S_SHIFT_RD;
      end

      // pack: keep marked entries, drop the rest
      S_PACK_RD: begin
        if (idx_r == fill_r) begin
          fill_nxt = wp_r;
          for (int i = 0; i < CAPACITY; i++) begin
            marks_nxt[i] = 1'b0;
          end
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else if (marks_r[idx_r[AW-1:0]]) begin
          state_nxt = S_PACK_WR;
        end else begin
          idx_nxt = idx_inc;
        end
      end

      S_PACK_WR: begin
        ram_we    = 1'b1;
        ram_waddr = wp_r[AW-1:0];
        wp_nxt    = wp_r + CW'(1);
        idx_nxt   = idx_inc;
        state_nxt = S_PACK_RD;
      end

      // dump: one element per read
      S_DUMP_RD: begin
        state_nxt = S_DUMP_OUT;
      end

      S_DUMP_OUT: begin
        emit        = 1'b1;
        emit_status = sis_pkg::ST_DUMP_ELEM;
        emit_elem   = 1'b1;
        emit_last   = (idx_inc == fill_r);
        idx_nxt     = idx_inc;
        state_nxt   = (idx_inc == fill_r) ? S_IDLE : S_DUMP_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // act on the scan outcome
    if (scan_done) begin
      case (cmd_r)
        sis_pkg::CMD_INSERT: begin
          if (scan_found) begin
            emit        = 1'b1;
            emit_status = sis_pkg::ST_NOCHANGE;
            state_nxt   = S_IDLE;
          end else if (fill_r == CW'(CAPACITY)) begin
            emit        = 1'b1;
            emit_status = sis_pkg::ST_FULL;
            state_nxt   = S_IDLE;
          end else begin
            idx_nxt   = fill_r;
            pos_nxt   = scan_pos;
            state_nxt = S_SHIFT_RD;
          end
        end
        sis_pkg::CMD_DELETE: begin
          if (scan_found) begin
            idx_nxt   = scan_pos;
            state_nxt = S_SHIFT_RD;
          end else begin
            emit        = 1'b1;
            emit_status = sis_pkg::ST_NOCHANGE;
            state_nxt   = S_IDLE;
          end
        end
        sis_pkg::CMD_INTERSECT: begin
          if (scan_found) begin
            marks_nxt[scan_pos[AW-1:0]] = 1'b1;
          end
          if (final_r) begin
            idx_nxt   = '0;
            wp_nxt    = '0;
            state_nxt = S_PACK_RD;
          end else begin
            emit        = 1'b1;
            emit_status = scan_found ? sis_pkg::ST_DONE : sis_pkg::ST_NOCHANGE;
            state_nxt   = S_IDLE;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end

    // build the result word
    fill_ext        = 32'(fill_nxt);
    out_valid_nxt   = emit;
    out_status_nxt  = emit_status;
    out_element_nxt = emit_elem ? rd_ext[31:0] : '0;
    out_size_nxt    = fill_ext[sis_pkg::SIZE_W-1:0];
    out_last_nxt    = emit_last;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
        marks_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        marks_r[i] <= marks_nxt[i];
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    key_r         <= key_nxt;
    scan_en_r     <= scan_en_nxt;
    final_r       <= final_nxt;
    idx_r         <= idx_nxt;
    pos_r         <= pos_nxt;
    wp_r          <= wp_nxt;
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_size_r    <= out_size_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_element    = out_element_r;
  assign out_size_now   = out_size_r;
  assign out_end_of_run = out_last_r;

`ifndef SYNTHESIS
  // fill count never passes the capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // an accepted word either starts work or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted word was lost");

  // only the dump run gives results that are not the last one
  a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_end_of_run) |-> (busy && out_status == sis_pkg::ST_DUMP_ELEM))
    else $error("intermediate result outside a dump");

  // element is zero unless a dump element is shown
  a_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != sis_pkg::ST_DUMP_ELEM) |-> (out_element == '0))
    else $error("element field not zero");
`endif

endmodule
`default_nettype wire

// ===== bench/sorted_integer_set_checker.sv =====
// ----------------------------------------------------------------------------
// sorted_integer_set_checker - result checker for the sorted integer set
// Watches the command and result channels. Keeps its own ordered copy of the
// set with intersect marks, predicts the results of each accepted word and
// compares them, in order, with what the block emits.
// ----------------------------------------------------------------------------
module sorted_integer_set_checker #(
  parameter int CAPACITY = sis_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic                              busy,
  input  wire logic [sis_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic signed [sis_pkg::ELEM_W-1:0] in_value,
  input  wire logic                              in_element_valid,
  input  wire logic                              in_final_element,
  input  wire logic                              out_valid,
  input  wire logic [sis_pkg::STATUS_W-1:0]      out_status,
  input  wire logic signed [sis_pkg::ELEM_W-1:0] out_element,
  input  wire logic [sis_pkg::SIZE_W-1:0]        out_size_now,
  input  wire logic                              out_end_of_run,
  output int                                     mismatch_count,
  output int                                     reports_pending
);

  typedef struct packed {
    logic [sis_pkg::STATUS_W-1:0] status;
    logic [sis_pkg::ELEM_W-1:0]   element;
    logic [sis_pkg::SIZE_W-1:0]   size_now;
    logic                         end_of_run;
  } set_report_t;

  // mirror of the store: ascending values, fill count and keep marks
  logic signed [sis_pkg::ELEM_W-1:0] set_vals [CAPACITY];
  logic                              keep_flags [CAPACITY];
  int                                set_size;

  set_report_t awaited_reports [$];

  // queue one report, stamped with the size after the step
  function automatic void post_report(logic [sis_pkg::STATUS_W-1:0] status,
                                      logic [sis_pkg::ELEM_W-1:0] element,
                                      logic last);
    set_report_t rpt;
    rpt.status     = status;
    rpt.element    = element;
    rpt.size_now   = sis_pkg::SIZE_W'(set_size);
    rpt.end_of_run = last;
    awaited_reports.push_back(rpt);
  endfunction

  // first slot holding a value not below the key, or set_size
  function automatic int find_slot(logic signed [sis_pkg::ELEM_W-1:0] key);
    int slot;
    slot = 0;
    while (slot < set_size && set_vals[slot] < key) slot++;
    return slot;
  endfunction

  // advance the mirror by one command word and queue its results
  task automatic apply_set_command(logic [sis_pkg::CMD_W-1:0] cmd,
                                   logic signed [sis_pkg::ELEM_W-1:0] value,
                                   logic elem_ok, logic commit);
    int slot;
    int kept;
    logic hit;
    logic [sis_pkg::STATUS_W-1:0] status;
    slot   = find_slot(value);
    hit    = (slot < set_size) && (set_vals[slot] == value);
    status = sis_pkg::ST_DONE;
    case (cmd)
      sis_pkg::CMD_INSERT: begin
        if (hit) begin
          status = sis_pkg::ST_NOCHANGE;
        end else if (set_size >= CAPACITY) begin
          status = sis_pkg::ST_FULL;
        end else begin
          // open a gap at the slot; marks travel with their entries
          for (int i = set_size; i > slot; i--) begin
            set_vals[i]   = set_vals[i-1];
            keep_flags[i] = keep_flags[i-1];
          end
          set_vals[slot]   = value;
          keep_flags[slot] = 1'b0;
          set_size++;
        end
        post_report(status, '0, 1'b1);
      end
      sis_pkg::CMD_DELETE: begin
        if (hit) begin
          for (int i = slot; i + 1 < set_size; i++) begin
            set_vals[i]   = set_vals[i+1];
            keep_flags[i] = keep_flags[i+1];
          end
          set_size--;
          keep_flags[set_size] = 1'b0;
        end else begin
          status = sis_pkg::ST_NOCHANGE;
        end
        post_report(status, '0, 1'b1);
      end
      sis_pkg::CMD_INTERSECT: begin
        status = sis_pkg::ST_NOCHANGE;
        if (elem_ok && hit) begin
          keep_flags[slot] = 1'b1;
          status = sis_pkg::ST_DONE;
        end
        // commit: compact the marked entries, drop the rest, clear marks
        if (commit) begin
          kept = 0;
          for (int i = 0; i < set_size; i++) begin
            if (keep_flags[i]) begin
              set_vals[kept] = set_vals[i];
              kept++;
            end
          end
          set_size = kept;
          foreach (keep_flags[i]) keep_flags[i] = 1'b0;
          status = sis_pkg::ST_DONE;
        end
        post_report(status, '0, 1'b1);
      end
      default: begin
        if (set_size == 0) begin
          post_report(sis_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < set_size; i++)
            post_report(sis_pkg::ST_DUMP_ELEM, set_vals[i], i == set_size - 1);
        end
      end
    endcase
  endtask

  // take accepted words first, then match any result against the oldest
  always @(posedge clk) begin : watch
    set_report_t seen;
    set_report_t want;
    if (!rst_n) begin
      set_size = 0;
      foreach (keep_flags[i]) keep_flags[i] = 1'b0;
      awaited_reports.delete();
    end else begin
      if (start && !busy)
        apply_set_command(in_cmd, in_value, in_element_valid, in_final_element);
      if (out_valid) begin
        seen = '{out_status, out_element, out_size_now, out_end_of_run};
        if (awaited_reports.size() == 0) begin
          $display("%0t: unexpected result: status %0d element %0d size %0d last %0b",
                   $time, seen.status, $signed(seen.element), seen.size_now,
                   seen.end_of_run);
          mismatch_count++;
        end else begin
          want = awaited_reports.pop_front();
          if (seen !== want) begin
            $display("%0t: result mismatch: expected status %0d element %0d size %0d last %0b",
                     $time, want.status, $signed(want.element), want.size_now,
                     want.end_of_run);
            $display("%0t:                    actual status %0d element %0d size %0d last %0b",
                     $time, seen.status, $signed(seen.element), seen.size_now,
                     seen.end_of_run);
            mismatch_count++;
          end
        end
      end
    end
    reports_pending = awaited_reports.size();
  end

endmodule

// ===== bench/tb_sorted_integer_set_top.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_integer_set_top - testbench for the sorted integer set
// Drives a directed run over empty, duplicate, extreme and intersect cases,
// then random insert, delete, intersect and dump words in bursts with gaps.
// A checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_sorted_integer_set_top;

  localparam int RANDOM_WORDS = 200;
  localparam logic signed [sis_pkg::ELEM_W-1:0] INT_LO = 32'sh8000_0000;
  localparam logic signed [sis_pkg::ELEM_W-1:0] INT_HI = 32'sh7fff_ffff;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic [sis_pkg::CMD_W-1:0]         in_cmd = sis_pkg::CMD_INSERT;
  logic signed [sis_pkg::ELEM_W-1:0] in_value = '0;
  logic                              in_element_valid = 1'b0;
  logic                              in_final_element = 1'b0;
  logic                              busy;
  logic                              out_valid;
  logic [sis_pkg::STATUS_W-1:0]      out_status;
  logic signed [sis_pkg::ELEM_W-1:0] out_element;
  logic [sis_pkg::SIZE_W-1:0]        out_size_now;
  logic                              out_end_of_run;
  int                                mismatch_count;
  int                                reports_pending;
  int                                words_sent = 0;
  int                                burst_left = 1;

  always #4 clk = ~clk;

  sorted_integer_set_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_value         (in_value),
    .in_element_valid (in_element_valid),
    .in_final_element (in_final_element),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_element      (out_element),
    .out_size_now     (out_size_now),
    .out_end_of_run   (out_end_of_run)
  );

  sorted_integer_set_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_value         (in_value),
    .in_element_valid (in_element_valid),
    .in_final_element (in_final_element),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_element      (out_element),
    .out_size_now     (out_size_now),
    .out_end_of_run   (out_end_of_run),
    .mismatch_count   (mismatch_count),
    .reports_pending  (reports_pending)
  );

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // mostly a narrow band so that values collide, sometimes extremes or any word
  function automatic logic signed [sis_pkg::ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       pick_value = INT_LO;
          1:       pick_value = INT_HI;
          2:       pick_value = 0;
          default: pick_value = -1;
        endcase
      end
      1, 2:    pick_value = $urandom;
      default: pick_value = int'($urandom_range(0, 24)) - 12;
    endcase
  endfunction

  function automatic int next_burst();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
  endfunction

  // present one word, hold it until accepted, then idle if the burst is over
  task automatic send_word(logic [sis_pkg::CMD_W-1:0] cmd,
                           logic signed [sis_pkg::ELEM_W-1:0] value,
                           logic elem_ok, logic commit);
    int gap;
    in_cmd           <= cmd;
    in_value         <= value;
    in_element_valid <= elem_ok;
    in_final_element <= commit;
    if (!start) start <= 1'b1;
    do @(posedge clk); while (busy);
    words_sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
      burst_left = next_burst();
    end
  endtask

  // drop start and hold off until every expected result has come back
  task automatic wait_for_drain();
    if (start) start <= 1'b0;
    do @(negedge clk); while (reports_pending != 0);
    burst_left = next_burst();
  endtask

  initial begin : stimulus
    int directed_words;
    int run_len;
    int stride;
    logic signed [sis_pkg::ELEM_W-1:0] base;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty set: dump, delete of an absent value, commit of an empty operand
    send_word(sis_pkg::CMD_DUMP, 0, 1'b1, 1'b0);
    send_word(sis_pkg::CMD_DELETE, 7, 1'b1, 1'b1);
    send_word(sis_pkg::CMD_INTERSECT, 0, 1'b0, 1'b1);
    // extremes, zero and minus one, then a duplicate
    send_word(sis_pkg::CMD_INSERT, INT_HI, 1'b0, 1'b1);
    send_word(sis_pkg::CMD_INSERT, INT_LO, 1'b1, 1'b0);
    send_word(sis_pkg::CMD_INSERT, 0, 1'b0, 1'b0);
    send_word(sis_pkg::CMD_INSERT, -1, 1'b1, 1'b1);
    send_word(sis_pkg::CMD_INSERT, 5, 1'b0, 1'b0);
    send_word(sis_pkg::CMD_INSERT, 5, 1'b1, 1'b0);
    send_word(sis_pkg::CMD_DUMP, INT_LO, 1'b0, 1'b1);
    // intersection with edits in the middle: marks must follow their entries
    send_word(sis_pkg::CMD_INTERSECT, INT_HI, 1'b1, 1'b0);
    send_word(sis_pkg::CMD_INTERSECT, 9, 1'b1, 1'b0);
    send_word(sis_pkg::CMD_INSERT, 3, 1'b0, 1'b0);
    send_word(sis_pkg::CMD_DELETE, INT_LO, 1'b0, 1'b0);
    send_word(sis_pkg::CMD_INTERSECT, 5, 1'b0, 1'b0);
    send_word(sis_pkg::CMD_INTERSECT, -1, 1'b1, 1'b1);
    send_word(sis_pkg::CMD_DUMP, 0, 1'b1, 1'b1);
    // commit with nothing marked empties the set
    send_word(sis_pkg::CMD_DELETE, INT_HI, 1'b1, 1'b0);
    send_word(sis_pkg::CMD_INTERSECT, 0, 1'b0, 1'b1);
    send_word(sis_pkg::CMD_DUMP, 0, 1'b0, 1'b0);
    directed_words = words_sent;
    wait_for_drain();

    while (words_sent < directed_words + RANDOM_WORDS) begin
      case ($urandom_range(0, 15))
        // intersect stream with the odd edit, closed by a commit
        7, 8, 9, 10: begin
          run_len = $urandom_range(0, 5);
          for (int k = 0; k < run_len; k++) begin
            if ($urandom_range(0, 5) == 0)
              send_word($urandom_range(0, 1) ? sis_pkg::CMD_INSERT : sis_pkg::CMD_DELETE,
                        pick_value(), 1'($urandom), 1'($urandom));
            else
              send_word(sis_pkg::CMD_INTERSECT, pick_value(),
                        $urandom_range(0, 7) != 0, 1'b0);
          end
          send_word(sis_pkg::CMD_INTERSECT, pick_value(), 1'($urandom), 1'b1);
        end
        // run of distinct inserts, at times long enough to reach full
        11: begin
          base   = pick_value();
          stride = $urandom_range(1, 4);
          run_len = $urandom_range(6, 18);
          for (int k = 0; k < run_len; k++)
            send_word(sis_pkg::CMD_INSERT, base + k * stride, 1'($urandom), 1'($urandom));
        end
        12, 13: begin
          run_len = $urandom_range(3, 8);
          for (int k = 0; k < run_len; k++)
            send_word(sis_pkg::CMD_DELETE, pick_value(), 1'($urandom), 1'($urandom));
        end
        14: send_word(sis_pkg::CMD_DUMP, pick_value(), 1'($urandom), 1'($urandom));
        15: begin
          wait_for_drain();
          send_word(sis_pkg::CMD_DUMP, pick_value(), 1'($urandom), 1'($urandom));
        end
        // single word of any kind, stray intersect commits included
        default: send_word(sis_pkg::CMD_W'($urandom_range(0, 3)), pick_value(),
                           1'($urandom), 1'($urandom));
      endcase
    end

    wait_for_drain();
    repeat (80) @(negedge clk);
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sorted_integer_set_top.f =====
rtl/core/sis_pkg.sv
rtl/core/sis_ram.sv
rtl/core/sorted_integer_set_top.sv
bench/sorted_integer_set_checker.sv
bench/tb_sorted_integer_set_top.sv
